// ----- rtl/core/assert_macros.svh -----
// assertion helpers, empty under synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("%m failed");
`define ASSERT_NORST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("%m failed");
`else
`define ASSERT_CLK(lbl, clk, rstn, prop)
`define ASSERT_NORST(lbl, clk, prop)
`endif
`endif

// ----- rtl/core/ame_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ame_pkg
// shared constants and opcodes of the accumulator machine executor
// ----------------------------------------------------------------------------
package ame_pkg;
  localparam int unsigned MemDepthDef = 256;
  localparam int unsigned WordBitsDef = 16;
  localparam int unsigned DataW = 16;
  localparam int unsigned PcW = 8;
  localparam int unsigned LenW = 9;
  localparam int unsigned StatW = 3;
  localparam int unsigned InW = 24;   // address + data
  localparam int unsigned OutW = 40;  // pc, acc, out_value
  localparam int unsigned UserW = 6;  // out_valid, used_input, halted, status

  localparam logic [3:0] OP_ADD = 4'd1, OP_SUB = 4'd2, OP_MUL = 4'd3, OP_DIV = 4'd4,
    OP_JMP = 4'd5, OP_JMPN = 4'd6, OP_JMPP = 4'd7, OP_JMPZ = 4'd8, OP_COPY = 4'd9,
    OP_LOAD = 4'd10, OP_STORE = 4'd11, OP_INPUT = 4'd12, OP_OUTPUT = 4'd13,
    OP_STOP = 4'd14;

  localparam logic [StatW-1:0] ST_RUN = 3'd0, ST_STOP = 3'd1, ST_DIV0 = 3'd2,
    ST_ILL = 3'd3, ST_END = 3'd4;
endpackage

// ----- rtl/core/ame_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ame_ram
// single port word memory with registered read
// ----------------------------------------------------------------------------
module ame_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[addr_i] <= wdata_i;
    rdata_o <= mem_q[addr_i];
  end
endmodule

// ----- rtl/core/accumulator_machine_executor_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// accumulator_machine_executor_unit
// accumulator machine with shared code/data memory and a sequenced datapath
// ----------------------------------------------------------------------------
// usage:
//   s_axis beat: tuser = func (0 write word, 1 execute one instruction),
//   tdata = {data, address}. one m_axis beat answers every input beat.
//   cfg_we_i/cfg_wdata_i write program_length while the block is idle.
// state sequence from the accepting edge (at most one ram read per state):
//   S_OUT for a memory write, an execute while halted or past the program end;
//   S_OPC, S_OUT for an illegal opcode; S_OPC, S_ARG, S_OUT for jumps, STORE,
//   INPUT and STOP; S_OPC, S_ARG, S_DAT, S_EXE, S_OUT for ADD, SUB, MUL, LOAD,
//   OUTPUT, a divide by zero, and COPY with S_CARG for S_EXE; DIV adds S_DIV per
//   quotient bit and S_DFIN after S_EXE. one item is in flight at a time;
//   s_axis_tready is low meanwhile and rises as the result is loaded.
// reset: pc, accumulator, halt flag and status clear, program_length = 256.
//   memory content is undefined until written.
// stall: the result sits in the output register until m_axis_tready; one
//   more beat is taken and worked off, and its result waits until the
//   output register is free.
module accumulator_machine_executor_unit #(
  parameter int unsigned MemDepth = ame_pkg::MemDepthDef,
  parameter int unsigned WordBits = ame_pkg::WordBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [ame_pkg::LenW-1:0] cfg_wdata_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [ame_pkg::InW-1:0]  s_axis_tdata,  // address[7:0], data[23:8]
  input  logic                  s_axis_tuser,  // func
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [ame_pkg::OutW-1:0] m_axis_tdata,  // pc_now, acc_now, out_value
  output logic [ame_pkg::UserW-1:0] m_axis_tuser  // out_valid, used_input, halted, status
);
  `include "assert_macros.svh"
  import ame_pkg::*;

  localparam int unsigned AW = $clog2(MemDepth);
  localparam int unsigned WB = WordBits;
  localparam int unsigned CW = $clog2(WB + 1);

  localparam logic [3:0] S_IDLE = 4'd0, S_OPC = 4'd2, S_ARG = 4'd3,
    S_DAT = 4'd4, S_EXE = 4'd5, S_DIV = 4'd6, S_DFIN = 4'd7, S_OUT = 4'd8,
    S_CARG = 4'd9;

  logic [3:0] st_q, st_d;
  logic [AW-1:0] pc_q, pc_d;
  logic [WB-1:0] acc_q, acc_d;
  logic halt_q, halt_d;
  logic [StatW-1:0] stat_q, stat_d;
  logic [LenW-1:0] len_q;
  logic [3:0] op_q, op_d;
  logic [WB-1:0] w_q, w_d;       // divider remainder
  logic [WB-1:0] din_q, din_d;
  logic [WB-1:0] quo_q, quo_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic ov_q, ov_d, used_q, used_d;
  logic [WB-1:0] ovv_q, ovv_d;
  logic mv_q;

  logic ram_we;
  logic [AW-1:0] ram_a;
  logic [WB-1:0] ram_wd, ram_rd;

  ame_ram #(.Width(WB), .Depth(MemDepth)) u_ram (
    .clk_i(clk_i), .we_i(ram_we), .addr_i(ram_a), .wdata_i(ram_wd), .rdata_o(ram_rd)
  );

  logic s_fire;
  assign s_axis_tready = (st_q == S_IDLE);
  assign s_fire = s_axis_tvalid && s_axis_tready;

  logic [LenW-1:0] limit;
  logic [WB-1:0] din_in;
  assign limit = (len_q == '0) ? '0 : len_q - 1'b1;
  assign din_in = WB'($signed(s_axis_tdata[8 +: DataW]));

  // divider helpers: magnitudes
  logic acc_neg, div_neg;
  logic [WB-1:0] acc_mag, div_mag;
  logic [WB:0] rem_try;
  assign acc_neg = acc_q[WB-1];
  assign div_neg = din_q[WB-1];
  assign acc_mag = acc_neg ? (~acc_q + 1'b1) : acc_q;
  assign div_mag = div_neg ? (~din_q + 1'b1) : din_q;
  assign rem_try = {w_q, quo_q[WB-1]} - {1'b0, div_mag};

  logic [2*WB-1:0] prod;
  assign prod = $signed(acc_q) * $signed(din_q);

  logic [AW-1:0] pc1, pc2, pc3;
  assign pc1 = pc_q + AW'(1);
  assign pc2 = pc_q + AW'(2);
  assign pc3 = pc_q + AW'(3);

  logic res_go;

  always_comb begin
    st_d = st_q; pc_d = pc_q; acc_d = acc_q; halt_d = halt_q; stat_d = stat_q;
    op_d = op_q; w_d = w_q; din_d = din_q; quo_d = quo_q;
    cnt_d = cnt_q; ov_d = ov_q; used_d = used_q; ovv_d = ovv_q;
    ram_we = 1'b0; ram_a = pc_q; ram_wd = din_q; res_go = 1'b0;
    unique case (st_q)
      S_IDLE: begin
        if (s_fire) begin
          ov_d = 1'b0; used_d = 1'b0; ovv_d = '0; din_d = din_in;
          if (!s_axis_tuser) begin
            ram_we = 1'b1; ram_a = AW'(s_axis_tdata[7:0]); ram_wd = din_in;
            st_d = S_OUT;
          end else if (halt_q) begin
            st_d = S_OUT;
          end else if (32'(pc_q) >= 32'(limit)) begin
            halt_d = 1'b1; stat_d = ST_END; st_d = S_OUT;
          end else begin
            ram_a = pc_q; st_d = S_OPC;
          end
        end
      end
      S_OPC: begin
        if ($signed(ram_rd) < 1 || $signed(ram_rd) > 14) begin
          halt_d = 1'b1; stat_d = ST_ILL; st_d = S_OUT;
        end else begin
          op_d = ram_rd[3:0]; ram_a = pc1; st_d = S_ARG;
        end
      end
      S_ARG: begin
        ram_a = AW'(ram_rd);
        st_d = S_DAT;
        if (op_q == OP_STOP) begin
          pc_d = pc1; halt_d = 1'b1; stat_d = ST_STOP; st_d = S_OUT;
        end else if (op_q == OP_STORE) begin
          ram_we = 1'b1; ram_wd = acc_q; pc_d = pc2; st_d = S_OUT;
        end else if (op_q == OP_INPUT) begin
          ram_we = 1'b1; ram_wd = din_q; used_d = 1'b1; pc_d = pc2; st_d = S_OUT;
        end else if (op_q == OP_JMP) begin
          pc_d = AW'(ram_rd); st_d = S_OUT;
        end else if (op_q == OP_JMPN) begin
          pc_d = acc_neg ? AW'(ram_rd) : pc2; st_d = S_OUT;
        end else if (op_q == OP_JMPP) begin
          pc_d = (!acc_neg && acc_q != '0) ? AW'(ram_rd) : pc2; st_d = S_OUT;
        end else if (op_q == OP_JMPZ) begin
          pc_d = (acc_q == '0) ? AW'(ram_rd) : pc2; st_d = S_OUT;
        end
      end
      S_DAT: begin
        din_d = ram_rd;
        st_d = S_EXE;
        if (op_q == OP_COPY) begin
          ram_a = pc2; st_d = S_CARG;
        end
      end
      S_CARG: begin
        ram_we = 1'b1; ram_a = AW'(ram_rd); ram_wd = din_q; pc_d = pc3; st_d = S_OUT;
      end
      S_EXE: begin
        pc_d = pc2; st_d = S_OUT;
        case (op_q)
          OP_ADD: acc_d = acc_q + din_q;
          OP_SUB: acc_d = acc_q - din_q;
          OP_MUL: acc_d = prod[WB-1:0];
          OP_LOAD: acc_d = din_q;
          OP_OUTPUT: begin ov_d = 1'b1; ovv_d = din_q; end
          OP_DIV: begin
            pc_d = pc_q;
            if (din_q == '0) begin
              halt_d = 1'b1; stat_d = ST_DIV0;
            end else begin
              w_d = '0; quo_d = acc_mag; cnt_d = CW'(WB); st_d = S_DIV;
            end
          end
          default: ;
        endcase
      end
      S_DIV: begin
        // restoring shift-subtract, one quotient bit a cycle
        if (!rem_try[WB]) begin
          w_d = rem_try[WB-1:0]; quo_d = {quo_q[WB-2:0], 1'b1};
        end else begin
          w_d = {w_q[WB-2:0], quo_q[WB-1]}; quo_d = {quo_q[WB-2:0], 1'b0};
        end
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == CW'(1)) st_d = S_DFIN;
      end
      S_DFIN: begin
        acc_d = (acc_neg ^ div_neg) ? (~quo_q + 1'b1) : quo_q;
        pc_d = pc2; st_d = S_OUT;
      end
      S_OUT: begin
        // wait here while the previous beat still sits in the output register
        if (!mv_q || m_axis_tready) begin
          res_go = 1'b1; st_d = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  logic [OutW-1:0] md_q;
  logic [UserW-1:0] mu_q;
  assign m_axis_tvalid = mv_q;
  assign m_axis_tdata = md_q;
  assign m_axis_tuser = mu_q;

  logic [WB-1:0] acc_res, ovv_res;
  assign acc_res = acc_q;
  assign ovv_res = ovv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; pc_q <= '0; acc_q <= '0; halt_q <= 1'b0; stat_q <= ST_RUN;
      len_q <= LenW'(256); mv_q <= 1'b0;
    end else begin
      st_q <= st_d; pc_q <= pc_d; acc_q <= acc_d; halt_q <= halt_d; stat_q <= stat_d;
      if (cfg_we_i) len_q <= cfg_wdata_i;
      if (res_go) mv_q <= 1'b1;
      else if (m_axis_tready) mv_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d; w_q <= w_d; din_q <= din_d; quo_q <= quo_d;
    cnt_q <= cnt_d; ov_q <= ov_d; used_q <= used_d; ovv_q <= ovv_d;
    if (res_go) begin
      md_q <= {DataW'($signed(ovv_res)), DataW'($signed(acc_res)), PcW'(pc_q)};
      mu_q <= {stat_q, halt_q, used_q, ov_q};
    end
  end

  `ASSERT_CLK(a_one_item, clk_i, rst_ni, s_fire |=> !s_axis_tready)
  `ASSERT_CLK(a_halt_stat, clk_i, rst_ni, halt_q == (stat_q != ST_RUN))
  `ASSERT_CLK(a_out_idle, clk_i, rst_ni, res_go |=> (st_q == S_IDLE && m_axis_tvalid))
  `ASSERT_CLK(a_stall_hold, clk_i, rst_ni,
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
endmodule
